>>> rtl/joystick_differential_pwm_drive_unit_macros.svh
`ifndef JOYSTICK_DIFFERENTIAL_PWM_DRIVE_UNIT_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_PWM_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jdpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JDPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jdpd assertion failed");

`endif

>>> rtl/jdpd_pkg.sv
`timescale 1ns / 1ps

package jdpd_pkg;

  localparam int PWM_TOP_DEF = 255;

  localparam int TRIM_W = 6;
  localparam int DUTY_W = 8;
  localparam int DIGIT_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_TRIM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TRIM  = 1'd1;

  localparam logic [TRIM_W-1:0] STRAIGHT_TRIM_RST = 6'd10;
  localparam logic [TRIM_W-1:0] REVERSE_TRIM_RST  = 6'd8;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_CENTER = 4'd4;
  localparam logic [DIGIT_W-1:0] DIGIT_RST    = 4'd1;

  localparam int PIN_FA = 0;
  localparam int PIN_FB = 1;
  localparam int PIN_RA = 2;
  localparam int PIN_RB = 3;

  localparam int LAMP_REV   = 0;
  localparam int LAMP_LEFT  = 1;
  localparam int LAMP_RIGHT = 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEC  = 3'b010,
    ST_EXE  = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic commit;
  } dp_cmd_t;

  // Duty for the speed taken from the vertical digit.
  function automatic logic [DUTY_W-1:0] speed_power(input logic [DIGIT_W-1:0] y);
    logic [DUTY_W-1:0] p;
    unique case (y)
      4'd0:    p = 8'd255;
      4'd1:    p = 8'd191;
      4'd2:    p = 8'd127;
      4'd3:    p = 8'd63;
      4'd5:    p = 8'd51;
      4'd6:    p = 8'd102;
      4'd7:    p = 8'd153;
      4'd8:    p = 8'd204;
      4'd9:    p = 8'd255;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

  // Duty for the turn magnitude taken from the horizontal digit.
  function automatic logic [DUTY_W-1:0] turn_power(input logic [DIGIT_W-1:0] x);
    logic [DUTY_W-1:0] p;
    unique case (x)
      4'd0, 4'd8, 4'd9: p = 8'd255;
      4'd1, 4'd7:       p = 8'd191;
      4'd2, 4'd6:       p = 8'd127;
      4'd3, 4'd5:       p = 8'd63;
      default:          p = 8'd0;
    endcase
    return p;
  endfunction

  // Remaining share of the inner wheel in quarters: (100 - |turn|) / 25.
  function automatic logic [2:0] turn_factor(input logic [DIGIT_W-1:0] x);
    logic [2:0] f;
    unique case (x)
      4'd1, 4'd7: f = 3'd1;
      4'd2, 4'd6: f = 3'd2;
      4'd3, 4'd5: f = 3'd3;
      4'd4:       f = 3'd4;
      default:    f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic [DUTY_W-1:0] sat_sub(input logic [DUTY_W-1:0] a,
                                                input logic [TRIM_W-1:0] b);
    logic [DUTY_W-1:0] bx;
    bx = DUTY_W'(b);
    return (a > bx) ? (a - bx) : '0;
  endfunction

endpackage

>>> rtl/jdpd_cmd_if.sv
`timescale 1ns / 1ps

interface jdpd_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [jdpd_pkg::DIGIT_W-1:0]     x_digit;
  logic [jdpd_pkg::DIGIT_W-1:0]     y_digit;
  logic                             digits_valid;

  modport source (output valid, opcode, x_digit, y_digit, digits_valid, input ready);
  modport sink (input valid, opcode, x_digit, y_digit, digits_valid, output ready);
endinterface

>>> rtl/jdpd_res_if.sv
`timescale 1ns / 1ps

interface jdpd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          fwd_pin_a;
  logic                          fwd_pin_b;
  logic                          rev_pin_a;
  logic                          rev_pin_b;
  logic [jdpd_pkg::DUTY_W-1:0]   duty_first;
  logic [jdpd_pkg::DUTY_W-1:0]   duty_second;
  logic                          reverse_lamp;
  logic                          left_lamp;
  logic                          right_lamp;

  modport source (output valid, fwd_pin_a, fwd_pin_b, rev_pin_a, rev_pin_b, duty_first,
                  duty_second, reverse_lamp, left_lamp, right_lamp, input ready);
  modport sink (input valid, fwd_pin_a, fwd_pin_b, rev_pin_a, rev_pin_b, duty_first,
                duty_second, reverse_lamp, left_lamp, right_lamp, output ready);
endinterface

>>> rtl/joystick_differential_pwm_drive_unit.sv
`timescale 1ns / 1ps

// Joystick differential drive with software PWM. Each accepted word is either a joystick
// command, which turns the two digits into the two motor duties, the lamps and the cleared
// direction pins, or a timer tick, which steps the PWM counter (0 to PWM_TOP) and drives the
// forward or reverse pin pair. Every word yields exactly one result word. The result word
// is offered after the controller's decode and execute states; a new word is taken only
// once the last one has left execute, and it is taken while the result still waits; only
// its execute step holds until that result is taken. The result fields are the block's
// state registers themselves. Trims are to be written through the configuration port
// while the block is idle; the block itself does not enforce this.
module joystick_differential_pwm_drive_unit #(
  parameter int PWM_TOP = jdpd_pkg::PWM_TOP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  jdpd_cmd_if.sink                          cmd_in,
  jdpd_res_if.source                        res_out,
  input  logic                              cfg_we_i,
  input  logic [jdpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jdpd_pkg::TRIM_W-1:0]       cfg_data_i
);

  jdpd_pkg::dp_cmd_t            cmd;
  logic [3:0]                   pins;
  logic [2:0]                   lamps;
  logic [jdpd_pkg::DUTY_W-1:0]  duty_first, duty_second;

  jdpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_in.valid),
    .in_ready_o  (cmd_in.ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .cmd_o       (cmd)
  );

  jdpd_dp #(
    .PWM_TOP (PWM_TOP)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (cmd_in.opcode),
    .x_digit_i      (cmd_in.x_digit),
    .y_digit_i      (cmd_in.y_digit),
    .digits_valid_i (cmd_in.digits_valid),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pins_o         (pins),
    .duty_first_o   (duty_first),
    .duty_second_o  (duty_second),
    .lamps_o        (lamps)
  );

  assign res_out.fwd_pin_a    = pins[jdpd_pkg::PIN_FA];
  assign res_out.fwd_pin_b    = pins[jdpd_pkg::PIN_FB];
  assign res_out.rev_pin_a    = pins[jdpd_pkg::PIN_RA];
  assign res_out.rev_pin_b    = pins[jdpd_pkg::PIN_RB];
  assign res_out.duty_first   = duty_first;
  assign res_out.duty_second  = duty_second;
  assign res_out.reverse_lamp = lamps[jdpd_pkg::LAMP_REV];
  assign res_out.left_lamp    = lamps[jdpd_pkg::LAMP_LEFT];
  assign res_out.right_lamp   = lamps[jdpd_pkg::LAMP_RIGHT];

endmodule

>>> rtl/jdpd_ctrl.sv
`timescale 1ns / 1ps

module jdpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jdpd_pkg::dp_cmd_t   cmd_o
);

  jdpd_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      jdpd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = jdpd_pkg::ST_DEC;
        end
      end
      jdpd_pkg::ST_DEC: begin
        cmd_o.decode = 1'b1;
        state_d      = jdpd_pkg::ST_EXE;
      end
      jdpd_pkg::ST_EXE: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = jdpd_pkg::ST_IDLE;
        end
      end
      default: state_d = jdpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jdpd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == jdpd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/jdpd_dp.sv
`timescale 1ns / 1ps

module jdpd_dp #(
  parameter int PWM_TOP = jdpd_pkg::PWM_TOP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jdpd_pkg::dp_cmd_t                 cmd_i,
  input  logic                              opcode_i,
  input  logic [jdpd_pkg::DIGIT_W-1:0]      x_digit_i,
  input  logic [jdpd_pkg::DIGIT_W-1:0]      y_digit_i,
  input  logic                              digits_valid_i,
  input  logic                              cfg_we_i,
  input  logic [jdpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jdpd_pkg::TRIM_W-1:0]       cfg_data_i,
  output logic [3:0]                        pins_o,
  output logic [jdpd_pkg::DUTY_W-1:0]       duty_first_o,
  output logic [jdpd_pkg::DUTY_W-1:0]       duty_second_o,
  output logic [2:0]                        lamps_o
);

  localparam int CntW = $clog2(PWM_TOP + 2);
  localparam int CmpW = (CntW > jdpd_pkg::DUTY_W) ? CntW : jdpd_pkg::DUTY_W;
  localparam int DW = jdpd_pkg::DUTY_W;
  localparam int GW = jdpd_pkg::DIGIT_W;

  // Accepted word.
  logic          op_q;
  logic [GW-1:0] x_q, y_q;
  logic          ok_q;

  // Decoded command.
  logic [DW-1:0] pwr_q, pwr_d;
  logic [2:0]    fac_q, fac_d;
  logic          spd_neg_q, spd_neg_d;
  logic          spd_zero_q, spd_zero_d;
  logic          turn_pos_q, turn_pos_d;
  logic          turn_neg_q, turn_neg_d;

  // Architectural state.
  logic [jdpd_pkg::TRIM_W-1:0] st_trim_q, rv_trim_q;
  logic [GW-1:0]   last_x_q, last_x_d, last_y_q, last_y_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   duty1_q, duty1_d, duty2_q, duty2_d;
  logic            neg_q, neg_d;
  logic [3:0]      pins_q, pins_d;
  logic [2:0]      lamps_q, lamps_d;

  logic            digits_ok;
  logic [GW-1:0]   ex, ey;
  logic [9:0]      prod;
  logic [DW-1:0]   reduced;
  logic [CntW-1:0] cnt_inc;
  logic            wrap;
  logic [CmpW-1:0] c_ext, d1_ext, d2_ext;

  always_comb begin
    digits_ok = ok_q && (x_q <= jdpd_pkg::DIGIT_MAX) && (y_q <= jdpd_pkg::DIGIT_MAX);
    ex        = digits_ok ? x_q : last_x_q;
    ey        = digits_ok ? y_q : last_y_q;
    last_x_d  = ex;
    last_y_d  = ey;
    spd_neg_d  = (ey < jdpd_pkg::DIGIT_CENTER);
    spd_zero_d = (ey == jdpd_pkg::DIGIT_CENTER);
    turn_neg_d = (ex < jdpd_pkg::DIGIT_CENTER);
    turn_pos_d = (ex > jdpd_pkg::DIGIT_CENTER);
    fac_d      = jdpd_pkg::turn_factor(ex);
    pwr_d      = spd_zero_d ? jdpd_pkg::turn_power(ex) : jdpd_pkg::speed_power(ey);
  end

  assign prod    = 10'(pwr_q) * 10'(fac_q);
  assign reduced = prod[9:2];

  assign cnt_inc = cnt_q + CntW'(1);
  assign wrap    = (cnt_inc > CntW'(PWM_TOP));
  assign c_ext   = CmpW'(cnt_inc);
  assign d1_ext  = CmpW'(duty1_q);
  assign d2_ext  = CmpW'(duty2_q);

  always_comb begin
    duty1_d = duty1_q;
    duty2_d = duty2_q;
    neg_d   = neg_q;
    pins_d  = pins_q;
    lamps_d = lamps_q;
    cnt_d   = cnt_q;
    if (op_q == jdpd_pkg::OP_TICK) begin
      cnt_d = wrap ? '0 : cnt_inc;
      if (!neg_q) begin
        pins_d[jdpd_pkg::PIN_FA] = (d1_ext > c_ext) || wrap;
        pins_d[jdpd_pkg::PIN_FB] = (d2_ext > c_ext) || wrap;
      end
      if ((duty1_q == '0) && (duty2_q == '0)) begin
        pins_d = '0;
      end
      if (neg_q) begin
        pins_d[jdpd_pkg::PIN_RA] = (d1_ext > c_ext) || wrap;
        pins_d[jdpd_pkg::PIN_RB] = (d2_ext > c_ext) || wrap;
      end
    end else begin
      neg_d                         = spd_neg_q;
      lamps_d[jdpd_pkg::LAMP_REV]   = spd_neg_q;
      lamps_d[jdpd_pkg::LAMP_LEFT]  = turn_neg_q;
      lamps_d[jdpd_pkg::LAMP_RIGHT] = turn_pos_q;
      if (spd_neg_q) begin
        pins_d[jdpd_pkg::PIN_FA] = 1'b0;
        pins_d[jdpd_pkg::PIN_FB] = 1'b0;
      end else begin
        pins_d[jdpd_pkg::PIN_RA] = 1'b0;
        pins_d[jdpd_pkg::PIN_RB] = 1'b0;
      end
      if (spd_zero_q) begin
        duty1_d = turn_neg_q ? pwr_q : '0;
        duty2_d = turn_pos_q ? pwr_q : '0;
      end else if (turn_pos_q) begin
        duty1_d = spd_neg_q ? jdpd_pkg::sat_sub(reduced, rv_trim_q) : reduced;
        duty2_d = pwr_q;
      end else if (turn_neg_q) begin
        duty1_d = spd_neg_q ? jdpd_pkg::sat_sub(pwr_q, rv_trim_q) : pwr_q;
        duty2_d = reduced;
      end else begin
        duty1_d = pwr_q;
        duty2_d = jdpd_pkg::sat_sub(pwr_q, st_trim_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      x_q  <= x_digit_i;
      y_q  <= y_digit_i;
      ok_q <= digits_valid_i;
    end
    if (cmd_i.decode) begin
      pwr_q      <= pwr_d;
      fac_q      <= fac_d;
      spd_neg_q  <= spd_neg_d;
      spd_zero_q <= spd_zero_d;
      turn_pos_q <= turn_pos_d;
      turn_neg_q <= turn_neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_trim_q <= jdpd_pkg::STRAIGHT_TRIM_RST;
      rv_trim_q <= jdpd_pkg::REVERSE_TRIM_RST;
      last_x_q  <= jdpd_pkg::DIGIT_RST;
      last_y_q  <= jdpd_pkg::DIGIT_RST;
      cnt_q     <= '0;
      duty1_q   <= '0;
      duty2_q   <= '0;
      neg_q     <= 1'b0;
      pins_q    <= '0;
      lamps_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          jdpd_pkg::REG_STRAIGHT_TRIM: st_trim_q <= cfg_data_i;
          jdpd_pkg::REG_REVERSE_TRIM:  rv_trim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decode && (op_q == jdpd_pkg::OP_CMD)) begin
        last_x_q <= last_x_d;
        last_y_q <= last_y_d;
      end
      if (cmd_i.commit) begin
        cnt_q   <= cnt_d;
        duty1_q <= duty1_d;
        duty2_q <= duty2_d;
        neg_q   <= neg_d;
        pins_q  <= pins_d;
        lamps_q <= lamps_d;
      end
    end
  end

  assign pins_o        = pins_q;
  assign duty_first_o  = duty1_q;
  assign duty_second_o = duty2_q;
  assign lamps_o       = lamps_q;

endmodule

>>> rtl/jdpd_checker.sv
`timescale 1ns / 1ps
`include "joystick_differential_pwm_drive_unit_macros.svh"

module jdpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic fwd_pin_a_i,
  input logic fwd_pin_b_i,
  input logic rev_pin_a_i,
  input logic rev_pin_b_i,
  input logic reverse_lamp_i
);

  // A result word that is not taken stays offered.
  `JDPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // One word at a time is in work: no acceptance in the cycle after one.
  `JDPD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // While reversing, the forward pair stays low.
  `JDPD_ASSERT_NOW(a_rev_no_fwd, clk_i, rst_ni, out_valid_i && reverse_lamp_i,
                   !fwd_pin_a_i && !fwd_pin_b_i)

  // Otherwise, the reverse pair stays low.
  `JDPD_ASSERT_NOW(a_fwd_no_rev, clk_i, rst_ni, out_valid_i && !reverse_lamp_i,
                   !rev_pin_a_i && !rev_pin_b_i)

endmodule

bind joystick_differential_pwm_drive_unit jdpd_checker u_jdpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (cmd_in.valid),
  .in_ready_i     (cmd_in.ready),
  .out_valid_i    (res_out.valid),
  .out_ready_i    (res_out.ready),
  .fwd_pin_a_i    (res_out.fwd_pin_a),
  .fwd_pin_b_i    (res_out.fwd_pin_b),
  .rev_pin_a_i    (res_out.rev_pin_a),
  .rev_pin_b_i    (res_out.rev_pin_b),
  .reverse_lamp_i (res_out.reverse_lamp)
);

>>> test/joystick_differential_pwm_drive_unit_tb.sv
`timescale 1ns / 1ps

module joystick_differential_pwm_drive_unit_tb;

  typedef struct packed {
    logic                         opcode;
    logic [jdpd_pkg::DIGIT_W-1:0] x_digit;
    logic [jdpd_pkg::DIGIT_W-1:0] y_digit;
    logic                         digits_valid;
  } drive_word_t;

  typedef struct packed {
    logic                        fwd_pin_a;
    logic                        fwd_pin_b;
    logic                        rev_pin_a;
    logic                        rev_pin_b;
    logic [jdpd_pkg::DUTY_W-1:0] duty_first;
    logic [jdpd_pkg::DUTY_W-1:0] duty_second;
    logic                        reverse_lamp;
    logic                        left_lamp;
    logic                        right_lamp;
  } drive_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [jdpd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [jdpd_pkg::TRIM_W-1:0]    cfg_data;

  jdpd_cmd_if cmd_bus ();
  jdpd_res_if res_bus ();

  joystick_differential_pwm_drive_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_in     (cmd_bus),
    .res_out    (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Drive state as the block should hold it.
  logic [8:0]                   pwm_cnt;
  logic [jdpd_pkg::DUTY_W-1:0]  duty_a;
  logic [jdpd_pkg::DUTY_W-1:0]  duty_b;
  int                           speed_pct;
  logic [jdpd_pkg::DIGIT_W-1:0] good_x;
  logic [jdpd_pkg::DIGIT_W-1:0] good_y;
  logic [3:0]                   pin_bits;
  logic [2:0]                   lamp_state;
  logic [jdpd_pkg::TRIM_W-1:0]  trim_straight;
  logic [jdpd_pkg::TRIM_W-1:0]  trim_reverse;

  drive_word_t   pending_q[$];
  drive_result_t expected_drive_q[$];
  drive_word_t   cur_word;
  drive_result_t predicted;
  logic          word_in_flight;
  logic          idling_on;
  int            send_gap;
  int            recv_gap;
  int            mismatch_count;
  int            results_checked;
  int            commands_seen;
  int            ticks_seen;
  int            wraps_seen;
  int            trim_settings;

  always #4 clk_i = ~clk_i;

  function automatic int clip_sub(input int a, input int b);
    return (a > b) ? a - b : 0;
  endfunction

  task automatic step_drive_model(input drive_word_t w, output drive_result_t r);
    int xi, yi, spd, trn, mag, pwr, red, da, db;
    if (w.opcode == jdpd_pkg::OP_TICK) begin
      ticks_seen++;
      pwm_cnt = pwm_cnt + 9'd1;
      if (speed_pct >= 0) begin
        pin_bits[jdpd_pkg::PIN_FA] = duty_a > pwm_cnt;
        pin_bits[jdpd_pkg::PIN_FB] = duty_b > pwm_cnt;
        if (pwm_cnt > jdpd_pkg::PWM_TOP_DEF) begin
          pwm_cnt = '0;
          pin_bits[jdpd_pkg::PIN_FA] = 1'b1;
          pin_bits[jdpd_pkg::PIN_FB] = 1'b1;
          wraps_seen++;
        end
      end
      if (duty_a == '0 && duty_b == '0) pin_bits = '0;
      if (speed_pct < 0) begin
        pin_bits[jdpd_pkg::PIN_RA] = duty_a > pwm_cnt;
        pin_bits[jdpd_pkg::PIN_RB] = duty_b > pwm_cnt;
        if (pwm_cnt > jdpd_pkg::PWM_TOP_DEF) begin
          pwm_cnt = '0;
          pin_bits[jdpd_pkg::PIN_RA] = 1'b1;
          pin_bits[jdpd_pkg::PIN_RB] = 1'b1;
          wraps_seen++;
        end
      end
    end else begin
      commands_seen++;
      if (w.digits_valid && w.x_digit <= jdpd_pkg::DIGIT_MAX &&
          w.y_digit <= jdpd_pkg::DIGIT_MAX) begin
        good_x = w.x_digit;
        good_y = w.y_digit;
      end
      xi = int'(good_x);
      yi = int'(good_y);
      if (yi > 4) spd = (yi - 4) * 20;
      else if (yi < 4) spd = (yi - 4) * 25;
      else spd = 0;
      trn = (xi - 4) * 25;
      if (trn > 100) trn = 100;
      speed_pct = spd;
      lamp_state[jdpd_pkg::LAMP_REV]   = spd < 0;
      lamp_state[jdpd_pkg::LAMP_LEFT]  = trn < 0;
      lamp_state[jdpd_pkg::LAMP_RIGHT] = trn > 0;
      mag = (trn < 0) ? -trn : trn;
      if (spd != 0) begin
        pwr = (255 * ((spd < 0) ? -spd : spd)) / 100;
        red = (pwr * (100 - mag)) / 100;
        if (spd > 0) begin
          pin_bits[jdpd_pkg::PIN_RA] = 1'b0;
          pin_bits[jdpd_pkg::PIN_RB] = 1'b0;
        end else begin
          pin_bits[jdpd_pkg::PIN_FA] = 1'b0;
          pin_bits[jdpd_pkg::PIN_FB] = 1'b0;
        end
        if (trn > 0) begin
          da = (spd > 0) ? red : clip_sub(red, int'(trim_reverse));
          db = pwr;
        end else if (trn < 0) begin
          da = (spd > 0) ? pwr : clip_sub(pwr, int'(trim_reverse));
          db = red;
        end else begin
          da = pwr;
          db = clip_sub(pwr, int'(trim_straight));
        end
      end else begin
        pin_bits[jdpd_pkg::PIN_RA] = 1'b0;
        pin_bits[jdpd_pkg::PIN_RB] = 1'b0;
        pwr = (255 * mag) / 100;
        da = (trn < 0) ? pwr : 0;
        db = (trn > 0) ? pwr : 0;
      end
      duty_a = jdpd_pkg::DUTY_W'(da);
      duty_b = jdpd_pkg::DUTY_W'(db);
    end
    r.fwd_pin_a    = pin_bits[jdpd_pkg::PIN_FA];
    r.fwd_pin_b    = pin_bits[jdpd_pkg::PIN_FB];
    r.rev_pin_a    = pin_bits[jdpd_pkg::PIN_RA];
    r.rev_pin_b    = pin_bits[jdpd_pkg::PIN_RB];
    r.duty_first   = duty_a;
    r.duty_second  = duty_b;
    r.reverse_lamp = lamp_state[jdpd_pkg::LAMP_REV];
    r.left_lamp    = lamp_state[jdpd_pkg::LAMP_LEFT];
    r.right_lamp   = lamp_state[jdpd_pkg::LAMP_RIGHT];
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    drive_result_t got, want;
    got = '{res_bus.fwd_pin_a, res_bus.fwd_pin_b, res_bus.rev_pin_a, res_bus.rev_pin_b,
            res_bus.duty_first, res_bus.duty_second, res_bus.reverse_lamp,
            res_bus.left_lamp, res_bus.right_lamp};
    if (expected_drive_q.size() == 0) begin
      report_mismatch("unexpected result words", 1, 0);
    end else begin
      want = expected_drive_q.pop_front();
      results_checked++;
      if (got.fwd_pin_a !== want.fwd_pin_a)
        report_mismatch("fwd_pin_a", got.fwd_pin_a, want.fwd_pin_a);
      if (got.fwd_pin_b !== want.fwd_pin_b)
        report_mismatch("fwd_pin_b", got.fwd_pin_b, want.fwd_pin_b);
      if (got.rev_pin_a !== want.rev_pin_a)
        report_mismatch("rev_pin_a", got.rev_pin_a, want.rev_pin_a);
      if (got.rev_pin_b !== want.rev_pin_b)
        report_mismatch("rev_pin_b", got.rev_pin_b, want.rev_pin_b);
      if (got.duty_first !== want.duty_first)
        report_mismatch("duty_first", got.duty_first, want.duty_first);
      if (got.duty_second !== want.duty_second)
        report_mismatch("duty_second", got.duty_second, want.duty_second);
      if (got.reverse_lamp !== want.reverse_lamp)
        report_mismatch("reverse_lamp", got.reverse_lamp, want.reverse_lamp);
      if (got.left_lamp !== want.left_lamp)
        report_mismatch("left_lamp", got.left_lamp, want.left_lamp);
      if (got.right_lamp !== want.right_lamp)
        report_mismatch("right_lamp", got.right_lamp, want.right_lamp);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        step_drive_model(cur_word, predicted);
        expected_drive_q.push_back(predicted);
        word_in_flight = 1'b0;
      end
      if (word_in_flight) begin
        cmd_bus.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (idling_on && pending_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        cmd_bus.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_word = pending_q.pop_front();
        word_in_flight = 1'b1;
        cmd_bus.opcode       <= cur_word.opcode;
        cmd_bus.x_digit      <= cur_word.x_digit;
        cmd_bus.y_digit      <= cur_word.y_digit;
        cmd_bus.digits_valid <= cur_word.digits_valid;
        cmd_bus.valid        <= 1'b1;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) check_result();
      if (recv_gap > 0) begin
        recv_gap--;
        res_bus.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic op, input logic [jdpd_pkg::DIGIT_W-1:0] x,
                            input logic [jdpd_pkg::DIGIT_W-1:0] y, input logic ok);
    drive_word_t w;
    w.opcode = op;
    w.x_digit = x;
    w.y_digit = y;
    w.digits_valid = ok;
    pending_q.push_back(w);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(jdpd_pkg::OP_TICK, jdpd_pkg::DIGIT_W'($urandom),
                          jdpd_pkg::DIGIT_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || word_in_flight || expected_drive_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_trim(input logic [jdpd_pkg::CFG_IDX_W-1:0] idx,
                            input logic [jdpd_pkg::TRIM_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == jdpd_pkg::REG_STRAIGHT_TRIM) trim_straight = val;
    else trim_reverse = val;
  endtask

  task automatic queue_random_drive(input int count);
    int n, run;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) != 0)
        queue_word(jdpd_pkg::OP_CMD, jdpd_pkg::DIGIT_W'($urandom_range(0, 9)),
                   jdpd_pkg::DIGIT_W'($urandom_range(0, 9)), 1'b1);
      else
        queue_word(jdpd_pkg::OP_CMD, jdpd_pkg::DIGIT_W'($urandom_range(0, 15)),
                   jdpd_pkg::DIGIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      run = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 280) : $urandom_range(0, 6);
      queue_ticks(run);
      n += run + 1;
    end
  endtask

  initial begin
    logic [jdpd_pkg::TRIM_W-1:0] trim_plan[5][2];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.opcode = jdpd_pkg::OP_CMD;
    cmd_bus.x_digit = '0;
    cmd_bus.y_digit = '0;
    cmd_bus.digits_valid = 1'b0;
    res_bus.ready = 1'b0;
    pwm_cnt = '0;
    duty_a = '0;
    duty_b = '0;
    speed_pct = 0;
    good_x = jdpd_pkg::DIGIT_RST;
    good_y = jdpd_pkg::DIGIT_RST;
    pin_bits = '0;
    lamp_state = '0;
    trim_straight = jdpd_pkg::STRAIGHT_TRIM_RST;
    trim_reverse = jdpd_pkg::REVERSE_TRIM_RST;
    word_in_flight = 1'b0;
    idling_on = 1'b1;
    send_gap = 0;
    recv_gap = 0;
    mismatch_count = 0;
    results_checked = 0;
    commands_seen = 0;
    ticks_seen = 0;
    wraps_seen = 0;
    trim_settings = 1;
    trim_plan = '{'{6'd0, 6'd0}, '{6'd63, 6'd63}, '{6'd50, 6'd0},
                  '{6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))}, '{6'd10, 6'd50}};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset trims: centre, pure turns, straight and turning in both directions,
    // a rejected word, and digits above nine.
    queue_word(jdpd_pkg::OP_TICK, 4'd0, 4'd0, 1'b0);
    queue_word(jdpd_pkg::OP_CMD, 4'd4, 4'd4, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd9, 4'd4, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd0, 4'd4, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd4, 4'd9, 1'b1);
    queue_ticks(2);
    queue_word(jdpd_pkg::OP_CMD, 4'd9, 4'd9, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd0, 4'd9, 1'b1);
    queue_word(jdpd_pkg::OP_CMD, 4'd4, 4'd0, 1'b1);
    queue_ticks(2);
    queue_word(jdpd_pkg::OP_CMD, 4'd9, 4'd0, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd0, 4'd0, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd7, 4'd2, 1'b0);
    queue_word(jdpd_pkg::OP_CMD, 4'd15, 4'd15, 1'b1);
    queue_word(jdpd_pkg::OP_CMD, 4'd3, 4'd10, 1'b1);
    queue_ticks(1);
    queue_word(jdpd_pkg::OP_CMD, 4'd6, 4'd8, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_trim(jdpd_pkg::REG_STRAIGHT_TRIM, trim_plan[p][0]);
      write_trim(jdpd_pkg::REG_REVERSE_TRIM, trim_plan[p][1]);
      trim_settings++;
      if (p == 4) idling_on = 1'b0;
      if (p == 4) queue_word(jdpd_pkg::OP_CMD, 4'd4, 4'd8, 1'b1);
      queue_random_drive(250);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d result words from %0d commands and %0d timer ticks.",
             results_checked, commands_seen, ticks_seen);
    $display("Used %0d trim settings; the PWM counter wrapped %0d times.",
             trim_settings, wraps_seen);
    if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
      $display("** joystick_differential_pwm_drive_unit: PASSED **");
    end else begin
      $display("** joystick_differential_pwm_drive_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d result words still expected.", expected_drive_q.size());
    $display("** joystick_differential_pwm_drive_unit: FAILED **");
    $finish;
  end

endmodule
